// ===== sv/stb_pkg.sv =====
// ---------------------------------------------------------------------------
// stb_pkg
// shared constants, codes and types of the saturating timer bank
// ---------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS  = 32;
  localparam int COUNT_WIDTH = 32;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SLOT_W = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W  = (SLOT_W > ID_W) ? SLOT_W : ID_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_COUNT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET_LIMIT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_ADD,
    OP_RESTART,
    OP_SET_COUNT,
    OP_SET_LIMIT,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TICK,
    B_QUERY,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_t                    op;
    logic [IDX_W-1:0]       idx;
    logic [COUNT_WIDTH-1:0] value;
    logic [SLOT_W-1:0]      nslots;
    status_t                status;
    logic [ID_W-1:0]        assigned;
  } cmd_t;

endpackage

// ===== sv/stb_if.sv =====
// ---------------------------------------------------------------------------
// stb_if
// request and result channels of the saturating timer bank
// ---------------------------------------------------------------------------
interface stb_in_if import stb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     timer_id;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output kind, output timer_id, output value, input ready);
  modport sink   (input valid, input kind, input timer_id, input value, output ready);
endinterface

interface stb_out_if import stb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     assigned_id;
  logic                elapsed;

  modport source (output valid, output status, output assigned_id, output elapsed, input ready);
  modport sink   (input valid, input status, input assigned_id, input elapsed, output ready);
endinterface

// ===== sv/stb_ram.sv =====
// ---------------------------------------------------------------------------
// stb_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/stb_front.sv =====
// ---------------------------------------------------------------------------
// stb_front
// accepts requests, checks ids, allocates slots and queues commands
// ---------------------------------------------------------------------------
module stb_front import stb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  stb_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [SLOT_W-1:0] slots_used_r;
  logic [SLOT_W-1:0] slots_used_nxt;
  logic              id_ok;
  cmd_t              cmd;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign id_ok       = CMP_W'(in_ch.timer_id) < CMP_W'(slots_used_r);

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.idx      = IDX_W'(in_ch.timer_id);
    cmd.value    = COUNT_WIDTH'(in_ch.value);
    cmd.nslots   = slots_used_r;
    cmd.status   = ST_OK;
    cmd.assigned = '0;
    unique case (in_ch.kind) inside
      KIND_TICK: begin
        cmd.op = OP_TICK;
      end
      KIND_ADD: begin
        if (slots_used_r < SLOT_W'(NUM_TIMERS)) begin
          cmd.op       = OP_ADD;
          cmd.idx      = IDX_W'(slots_used_r);
          cmd.assigned = ID_W'(slots_used_r);
        end else begin
          cmd.status = ST_FULL;
        end
      end
      KIND_RESTART, KIND_SET_COUNT, KIND_SET_LIMIT, KIND_QUERY: begin
        if (!id_ok) begin
          cmd.status = ST_BAD_ID;
        end else if (in_ch.kind == KIND_RESTART) begin
          cmd.op = OP_RESTART;
        end else if (in_ch.kind == KIND_SET_COUNT) begin
          cmd.op = OP_SET_COUNT;
        end else if (in_ch.kind == KIND_SET_LIMIT) begin
          cmd.op = OP_SET_LIMIT;
        end else begin
          cmd.op = OP_QUERY;
        end
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

  assign q_cmd = cmd;

  always_comb begin
    slots_used_nxt = slots_used_r;
    if (q_push && cmd.op == OP_ADD) begin
      slots_used_nxt = slots_used_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
    end else begin
      slots_used_r <= slots_used_nxt;
    end
  end

endmodule

// ===== sv/stb_queue.sv =====
// ---------------------------------------------------------------------------
// stb_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module stb_queue import stb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic pop,
  input  cmd_t push_cmd,
  output logic full,
  output logic empty,
  output cmd_t head_cmd
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] wp_nxt;
  logic [QPTR_W-1:0] rp_r;
  logic [QPTR_W-1:0] rp_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign empty    = cnt_r == '0;
  assign head_cmd = entry_r[rp_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/stb_back.sv =====
// ---------------------------------------------------------------------------
// stb_back
// executes queued commands on the counter and limit memories
// ---------------------------------------------------------------------------
module stb_back import stb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  cmd_t     head_cmd,
  output logic     q_pop,
  stb_out_if.source out_ch
);

  back_state_t            st_r;
  back_state_t            st_nxt;
  cmd_t                   cmd_r;
  cmd_t                   cmd_nxt;
  logic [SLOT_W-1:0]      rd_idx_r;
  logic [SLOT_W-1:0]      rd_idx_nxt;
  logic [IDX_W-1:0]       wr_idx_r;
  logic [IDX_W-1:0]       wr_idx_nxt;
  logic                   elapsed_r;
  logic                   elapsed_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  status_t                out_status_r;
  status_t                out_status_nxt;
  logic [ID_W-1:0]        out_id_r;
  logic [ID_W-1:0]        out_id_nxt;
  logic                   out_elapsed_r;
  logic                   out_elapsed_nxt;

  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [IDX_W-1:0]       cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   lim_we;
  logic [IDX_W-1:0]       lim_waddr;
  logic [COUNT_WIDTH-1:0] lim_wdata;
  logic [IDX_W-1:0]       lim_raddr;
  logic [COUNT_WIDTH-1:0] lim_q;

  stb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  stb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_limit_ram (
    .clk   (clk),
    .we    (lim_we),
    .waddr (lim_waddr),
    .wdata (lim_wdata),
    .raddr (lim_raddr),
    .rdata (lim_q)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.assigned_id = out_id_r;
  assign out_ch.elapsed     = out_elapsed_r;

  always_comb begin
    st_nxt          = st_r;
    cmd_nxt         = cmd_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    elapsed_nxt     = elapsed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_elapsed_nxt = out_elapsed_r;
    q_pop           = 1'b0;
    cnt_we          = 1'b0;
    cnt_waddr       = head_cmd.idx;
    cnt_wdata       = '0;
    cnt_raddr       = head_cmd.idx;
    lim_we          = 1'b0;
    lim_waddr       = head_cmd.idx;
    lim_wdata       = head_cmd.value;
    lim_raddr       = head_cmd.idx;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = head_cmd;
          elapsed_nxt = 1'b0;
          st_nxt      = B_DONE;
          case (head_cmd.op)
            OP_ADD: begin
              cnt_we = 1'b1;
              lim_we = 1'b1;
            end
            OP_RESTART: begin
              cnt_we = 1'b1;
            end
            OP_SET_COUNT: begin
              cnt_we    = 1'b1;
              cnt_wdata = head_cmd.value;
            end
            OP_SET_LIMIT: begin
              lim_we = 1'b1;
            end
            OP_QUERY: begin
              st_nxt = B_QUERY;
            end
            OP_TICK: begin
              // read slot 0 now, slot i+1 is read while slot i is written
              cnt_raddr = '0;
              lim_raddr = '0;
              if (head_cmd.nslots != '0) begin
                rd_idx_nxt = SLOT_W'(1);
                wr_idx_nxt = '0;
                st_nxt     = B_TICK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_TICK: begin
        cnt_raddr = rd_idx_r[IDX_W-1:0];
        lim_raddr = rd_idx_r[IDX_W-1:0];
        cnt_waddr = wr_idx_r;
        cnt_wdata = cnt_q + COUNT_WIDTH'(1);
        cnt_we    = cnt_q < lim_q;
        if (rd_idx_r < cmd_r.nslots) begin
          wr_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + SLOT_W'(1);
        end else begin
          st_nxt = B_DONE;
        end
      end
      B_QUERY: begin
        elapsed_nxt = cnt_q == lim_q;
        st_nxt      = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = cmd_r.status;
          out_id_nxt      = cmd_r.assigned;
          out_elapsed_nxt = elapsed_r;
          st_nxt          = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    rd_idx_r      <= rd_idx_nxt;
    wr_idx_r      <= wr_idx_nxt;
    elapsed_r     <= elapsed_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_elapsed_r <= out_elapsed_nxt;
  end

endmodule

// ===== sv/saturating_timer_bank.sv =====
// ---------------------------------------------------------------------------
// saturating_timer_bank
// bank of saturating up-counting timers with allocate, tick and query
// ---------------------------------------------------------------------------
// channel   dir   handshake       payload
// in_ch     in    valid / ready   kind, timer_id, value
// out_ch    out   valid / ready   status, assigned_id, elapsed
//
// one result per request, in request order
// a tick updates one counter memory entry per cycle, for every used slot
// requests queue two deep ahead of the execution side, results wait in
// an output register, so either side may stall without losing requests
// synchronous active-low reset, no clearing pass after reset
// ---------------------------------------------------------------------------
module saturating_timer_bank import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch
);

  cmd_t   push_cmd;
  cmd_t   head_cmd;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  stb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  stb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .pop      (q_pop),
    .push_cmd (push_cmd),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  stb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head_cmd (head_cmd),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
